// File: src/usb_audio_rate_estimator_top_defines.svh
`ifndef USB_AUDIO_RATE_ESTIMATOR_TOP_DEFINES_SVH
`define USB_AUDIO_RATE_ESTIMATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define USBARE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define USBARE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define USBARE_ASSERT_NOW(lbl, ante, cons)
`define USBARE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: src/usbare_pkg.sv
package usbare_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLOSE,
    ST_NOMDIV,
    ST_DIV1,
    ST_DIV2,
    ST_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_NORM,
    DV_CALC
  } div_state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [31:0]       m;
    logic signed [7:0] e;
  } div_rsp_t;

  localparam logic [31:0] NOMINAL_Q31 = 32'h8000_0000;

  localparam logic [1:0] REG_NOMINAL    = 2'd0;
  localparam logic [1:0] REG_REF_TICKS  = 2'd1;
  localparam logic [1:0] REG_PERIOD     = 2'd2;
  localparam logic [1:0] REG_IDLE_LIMIT = 2'd3;

  localparam logic [23:0] RST_NOMINAL    = 24'd128000;
  localparam logic [31:0] RST_REF_TICKS  = 32'd100000000;
  localparam logic [31:0] RST_PERIOD     = 32'd25000000;
  localparam logic [7:0]  RST_IDLE_LIMIT = 8'd8;

  localparam logic [7:0] IDLE_SAT = 8'hFF;

  function automatic logic [31:0] to_q31(input logic [31:0] m, input logic signed [7:0] e);
    logic [7:0]  rsh;
    logic [7:0]  rsh_m1;
    logic [31:0] hi;
    logic        rb;
    rsh    = 8'(-8'sd31 - e);
    rsh_m1 = rsh - 8'd1;
    hi     = (rsh >= 8'd32) ? 32'd0 : (m >> rsh[4:0]);
    rb     = (rsh_m1 >= 8'd32) ? 1'b0 : m[rsh_m1[4:0]];
    if (e < -8'sd31) begin
      return hi + {31'd0, rb};
    end else if (e > -8'sd31) begin
      return 32'hFFFF_FFFF;
    end
    return m;
  endfunction

endpackage

// File: src/usbare_div.sv
module usbare_div
  import usbare_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  div_state_t        state_r, state_nxt;
  logic [31:0]       na_r, na_nxt;
  logic [31:0]       nb_r, nb_nxt;
  logic [4:0]        za_r, za_nxt;
  logic [4:0]        zb_r, zb_nxt;
  logic [32:0]       rem_r, rem_nxt;
  logic [31:0]       q_r, q_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic              pre31_r, pre31_nxt;
  logic [31:0]       m_r, m_nxt;
  logic signed [7:0] e_r, e_nxt;
  logic              done_r, done_nxt;
  logic              qbit;
  logic [32:0]       diff;

  always_comb begin
    state_nxt = state_r;
    na_nxt    = na_r;
    nb_nxt    = nb_r;
    za_nxt    = za_r;
    zb_nxt    = zb_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    pre31_nxt = pre31_r;
    m_nxt     = m_r;
    e_nxt     = e_r;
    done_nxt  = 1'b0;
    qbit      = (rem_r >= {1'b0, nb_r});
    diff      = qbit ? (rem_r - {1'b0, nb_r}) : rem_r;
    unique case (state_r)
      DV_IDLE: begin
        if (req.start) begin
          na_nxt    = req.a;
          nb_nxt    = req.b;
          za_nxt    = '0;
          zb_nxt    = '0;
          state_nxt = DV_NORM;
        end
      end
      DV_NORM: begin
        if (!na_r[31]) begin
          na_nxt = {na_r[30:0], 1'b0};
          za_nxt = za_r + 5'd1;
        end
        if (!nb_r[31]) begin
          nb_nxt = {nb_r[30:0], 1'b0};
          zb_nxt = zb_r + 5'd1;
        end
        if (na_r[31] && nb_r[31]) begin
          pre31_nxt = (na_r >= nb_r);
          rem_nxt   = (na_r >= nb_r) ? {1'b0, na_r} : {na_r, 1'b0};
          q_nxt     = '0;
          cnt_nxt   = 5'd31;
          state_nxt = DV_CALC;
        end
      end
      DV_CALC: begin
        q_nxt   = {q_r[30:0], qbit};
        rem_nxt = {diff[31:0], 1'b0};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          m_nxt     = {q_r[30:0], qbit};
          e_nxt     = $signed({3'b0, zb_r}) - $signed({3'b0, za_r})
                      - (pre31_r ? 8'sd31 : 8'sd32);
          done_nxt  = 1'b1;
          state_nxt = DV_IDLE;
        end
      end
      default: state_nxt = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    na_r    <= na_nxt;
    nb_r    <= nb_nxt;
    za_r    <= za_nxt;
    zb_r    <= zb_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    cnt_r   <= cnt_nxt;
    pre31_r <= pre31_nxt;
    m_r     <= m_nxt;
    e_r     <= e_nxt;
  end

  assign rsp.busy = (state_r != DV_IDLE);
  assign rsp.done = done_r;
  assign rsp.m    = m_r;
  assign rsp.e    = e_r;

endmodule

// File: src/usb_audio_rate_estimator_top.sv
// channel  | direction | handshake            | payload
// cfg      | in        | cfg_we               | cfg_index, cfg_wdata
// in       | in        | in_valid / in_stall  | op, channel, timestamp, byte_count, want_rate
// out      | out       | out_valid / out_stall| rate_ratio, rate_channel
// start-of-frame tick: accept, execute; restart item: execute, one division when the nominal rate is valid, done
// data item: execute, close, plus two divisions when a rate is computed, done
// one division normalizes both operands, forms the quotient bits, then signals done
// ring entries are undefined after reset; ring_full gates their use, no clearing pass
// out_stall holds the output register; the next item is taken meanwhile but waits in ST_DONE
`include "usb_audio_rate_estimator_top_defines.svh"

module usb_audio_rate_estimator_top
  import usbare_pkg::*;
#(
  parameter int BUCKETS  = 64,
  parameter int CHANNELS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic        in_channel,
  input  logic [31:0] in_timestamp,
  input  logic [15:0] in_byte_count,
  input  logic        in_want_rate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_rate_ratio,
  output logic        out_rate_channel
);

  localparam int PW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW  = $clog2(CHANNELS * BUCKETS);

  seq_state_t state_r, state_nxt;

  logic [23:0] nom_bps_r;
  logic [31:0] ref_tps_r;
  logic [31:0] period_r;
  logic [7:0]  idle_limit_r;

  logic        restart_pend_r [CHANNELS];
  logic        seen_r         [CHANNELS];
  logic [7:0]  idle_frames_r  [CHANNELS];
  logic [31:0] start_time_r   [CHANNELS];
  logic [31:0] open_bytes_r   [CHANNELS];
  logic [PW-1:0] ring_pos_r   [CHANNELS];
  logic        ring_full_r    [CHANNELS];
  logic [31:0] win_bytes_r    [CHANNELS];
  logic [31:0] win_ticks_r    [CHANNELS];
  logic [31:0] exp_m_r;
  logic signed [7:0] exp_e_r;

  logic        op_r, chan_r, want_r;
  logic [31:0] ts_r;
  logic [15:0] bytes_r;

  logic [31:0] span_r, open_new_r, tot_b_r, tot_t_r, result_r;
  logic        close_r, do_div_r;
  logic signed [7:0] e1_r;
  logic [AW-1:0] addr_r;

  logic [63:0] ring_mem [CHANNELS*BUCKETS];
  logic [63:0] rdata_r;

  logic        out_valid_r;
  logic [31:0] out_ratio_r;
  logic        out_chan_r;

  logic [CIW-1:0] ci;
  logic        chan_ok;
  logic [31:0] open_new, span, tot_b, tot_t;
  logic [AW-1:0] ring_addr;
  logic [31:0] old_b, old_t;
  logic        out_load;
  logic        nom_ok;
  logic [7:0]  idle_inc [CHANNELS];
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  assign ci       = CIW'(chan_r);
  assign chan_ok  = ({31'd0, chan_r} < 32'(CHANNELS));
  assign open_new = open_bytes_r[ci] + {16'd0, bytes_r};
  assign span     = ts_r - start_time_r[ci];
  assign tot_b    = open_new + win_bytes_r[ci];
  assign tot_t    = span + win_ticks_r[ci];
  assign ring_addr = AW'(ci) * AW'(BUCKETS) + AW'(ring_pos_r[ci]);
  assign old_b    = ring_full_r[ci] ? rdata_r[63:32] : 32'd0;
  assign old_t    = ring_full_r[ci] ? rdata_r[31:0] : 32'd0;
  assign nom_ok   = (nom_bps_r != 24'd0) && (ref_tps_r != 32'd0);

  always_comb begin
    for (int k = 0; k < CHANNELS; k++) begin
      idle_inc[k] = (idle_frames_r[k] == IDLE_SAT) ? idle_frames_r[k]
                                                   : idle_frames_r[k] + 8'd1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    div_req.start = 1'b0;
    div_req.a     = tot_b_r;
    div_req.b     = tot_t_r;
    out_load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        priority if (op_r || !chan_ok) begin
          state_nxt = ST_IDLE;
        end else if (restart_pend_r[ci]) begin
          if (nom_ok) begin
            div_req.start = 1'b1;
            div_req.a     = {8'd0, nom_bps_r};
            div_req.b     = ref_tps_r;
            state_nxt     = ST_NOMDIV;
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          state_nxt = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        if (do_div_r) begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV1;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_NOMDIV: begin
        if (div_rsp.done) state_nxt = ST_DONE;
      end
      ST_DIV1: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          div_req.a     = div_rsp.m;
          div_req.b     = exp_m_r;
          state_nxt     = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div_rsp.done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nom_bps_r    <= RST_NOMINAL;
      ref_tps_r    <= RST_REF_TICKS;
      period_r     <= RST_PERIOD;
      idle_limit_r <= RST_IDLE_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NOMINAL:    nom_bps_r    <= cfg_wdata[23:0];
        REG_REF_TICKS:  ref_tps_r    <= cfg_wdata;
        REG_PERIOD:     period_r     <= cfg_wdata;
        REG_IDLE_LIMIT: idle_limit_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // per-channel state and shared nominal rate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CHANNELS; k++) begin
        restart_pend_r[k] <= 1'b1;
        seen_r[k]         <= 1'b0;
        idle_frames_r[k]  <= '0;
        start_time_r[k]   <= '0;
        open_bytes_r[k]   <= '0;
        ring_pos_r[k]     <= '0;
        ring_full_r[k]    <= 1'b0;
        win_bytes_r[k]    <= '0;
        win_ticks_r[k]    <= '0;
      end
      exp_m_r <= '0;
      exp_e_r <= '0;
    end else begin
      if (state_r == ST_EXEC && op_r) begin
        for (int k = 0; k < CHANNELS; k++) begin
          if (seen_r[k]) begin
            idle_frames_r[k] <= '0;
            seen_r[k]        <= 1'b0;
          end else begin
            idle_frames_r[k] <= idle_inc[k];
            if (idle_inc[k] > idle_limit_r) restart_pend_r[k] <= 1'b1;
          end
        end
      end else if (state_r == ST_EXEC && chan_ok) begin
        seen_r[ci] <= 1'b1;
        if (restart_pend_r[ci]) begin
          restart_pend_r[ci] <= 1'b0;
          start_time_r[ci]   <= ts_r;
          open_bytes_r[ci]   <= '0;
          ring_pos_r[ci]     <= '0;
          ring_full_r[ci]    <= 1'b0;
          win_bytes_r[ci]    <= '0;
          win_ticks_r[ci]    <= '0;
          if (!nom_ok) begin
            exp_m_r <= '0;
            exp_e_r <= '0;
          end
        end else begin
          open_bytes_r[ci] <= open_new;
        end
      end
      if (state_r == ST_CLOSE && close_r) begin
        win_bytes_r[ci]  <= win_bytes_r[ci] + (open_new_r - old_b);
        win_ticks_r[ci]  <= win_ticks_r[ci] + (span_r - old_t);
        open_bytes_r[ci] <= '0;
        start_time_r[ci] <= ts_r;
        if (ring_pos_r[ci] == PW'(BUCKETS - 1)) begin
          ring_pos_r[ci]  <= '0;
          ring_full_r[ci] <= 1'b1;
        end else begin
          ring_pos_r[ci] <= ring_pos_r[ci] + PW'(1);
        end
      end
      if (state_r == ST_NOMDIV && div_rsp.done) begin
        exp_m_r <= div_rsp.m;
        exp_e_r <= div_rsp.e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      op_r    <= in_op;
      chan_r  <= in_channel;
      ts_r    <= in_timestamp;
      bytes_r <= in_byte_count;
      want_r  <= in_want_rate;
    end
    if (state_r == ST_EXEC) begin
      span_r     <= span;
      open_new_r <= open_new;
      tot_b_r    <= tot_b;
      tot_t_r    <= tot_t;
      close_r    <= (span >= period_r);
      do_div_r   <= want_r && (tot_b != 32'd0) && (tot_t != 32'd0) && (exp_m_r != 32'd0);
      addr_r     <= ring_addr;
      result_r   <= NOMINAL_Q31;
    end
    if (state_r == ST_DIV1 && div_rsp.done) begin
      e1_r <= div_rsp.e;
    end
    if (state_r == ST_DIV2 && div_rsp.done) begin
      result_r <= to_q31(div_rsp.m, e1_r + div_rsp.e - exp_e_r);
    end
    if (out_load) begin
      out_ratio_r <= result_r;
      out_chan_r  <= chan_r;
    end
  end

  // ring of closed buckets: bytes in the upper word, ticks in the lower
  always_ff @(posedge clk) begin
    if (state_r == ST_CLOSE && close_r) begin
      ring_mem[addr_r] <= {open_new_r, span_r};
    end
    if (state_r == ST_EXEC) begin
      rdata_r <= ring_mem[ring_addr];
    end
  end

  usbare_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_rate_ratio   = out_ratio_r;
  assign out_rate_channel = out_chan_r;

  `USBARE_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall)
  `USBARE_ASSERT_NOW(a_div_start_free, div_req.start, !div_rsp.busy)
  `USBARE_ASSERT_NEXT(a_done_loads, out_load, state_r == ST_IDLE && out_valid_r)

endmodule

// File: tb/tb_top.sv
module tb_top;
  import usbare_pkg::*;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_SOF  = 1'b1;
  localparam int   NCH     = 2;
  localparam int   NBUCKET = 64;
  localparam int   CYCLE_LIMIT = 2000000;
  localparam int   DRAIN_CYCLES = 200;

  typedef struct {
    logic        op;
    logic        ch;
    logic [31:0] ts;
    logic [15:0] nbytes;
    logic        want;
  } packet_t;

  typedef struct {
    logic [31:0] ratio;
    logic        ch;
  } rate_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        in_op;
  logic        in_channel;
  logic [31:0] in_timestamp;
  logic [15:0] in_byte_count;
  logic        in_want_rate;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_rate_ratio;
  logic        out_rate_channel;

  usb_audio_rate_estimator_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_channel       (in_channel),
    .in_timestamp     (in_timestamp),
    .in_byte_count    (in_byte_count),
    .in_want_rate     (in_want_rate),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rate_ratio   (out_rate_ratio),
    .out_rate_channel (out_rate_channel)
  );

  // register mirror
  logic [23:0] nominal_bps;
  logic [31:0] ref_tps;
  logic [31:0] period_ticks;
  logic [7:0]  idle_limit;

  // per channel estimator state
  logic        restart_pend [NCH];
  logic        frame_data   [NCH];
  logic [7:0]  idle_cnt     [NCH];
  logic [31:0] bucket_t0    [NCH];
  logic [31:0] open_bytes   [NCH];
  int          ring_pos     [NCH];
  logic [31:0] ring_bytes   [NCH][NBUCKET];
  logic [31:0] ring_ticks   [NCH][NBUCKET];
  logic [31:0] win_bytes    [NCH];
  logic [31:0] win_ticks    [NCH];
  logic [31:0] nom_mant;
  int          nom_exp;

  packet_t packet_queue[$];
  rate_t   pending_rates[$];

  logic in_fire;
  int   accepted;
  int   errors;
  int   cycles;
  int   tsg [NCH];

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic int lead_zeros(logic [31:0] v);
    int n;
    n = 0;
    while (n < 32 && !v[31]) begin
      v = v << 1;
      n++;
    end
    return n;
  endfunction

  function automatic void norm_divide(input logic [31:0] a, input int ea,
                                      input logic [31:0] b, input int eb,
                                      output logic [31:0] m, output int e);
    int za, zb, pre;
    logic [63:0] na, nb, q;
    za = lead_zeros(a);
    zb = lead_zeros(b);
    na = {32'd0, a << za};
    nb = {32'd0, b << zb};
    pre = (na >= nb) ? 31 : 32;
    q = (na << pre) / nb;
    m = q[31:0];
    e = (ea - za) - (eb - zb) - pre;
  endfunction

  function automatic logic [31:0] q31_of(logic [31:0] m, int e);
    int rsh;
    logic [63:0] w, hi, rb;
    if (e < -31) begin
      rsh = -31 - e;
      w = {32'd0, m};
      hi = (rsh < 64) ? (w >> rsh) : 64'd0;
      rb = (rsh - 1 < 64) ? ((w >> (rsh - 1)) & 64'd1) : 64'd0;
      return 32'(hi + rb);
    end
    if (e > -31) return 32'hFFFF_FFFF;
    return m;
  endfunction

  task automatic estimate_rate(packet_t p);
    int c, pos, e1, e2;
    logic [31:0] span, tb_sum, tt_sum, m1, m2;
    rate_t r;
    if (p.op == OP_SOF) begin
      for (int k = 0; k < NCH; k++) begin
        if (frame_data[k]) begin
          idle_cnt[k] = 8'd0;
          frame_data[k] = 1'b0;
        end else begin
          if (idle_cnt[k] < IDLE_SAT) idle_cnt[k]++;
          if (idle_cnt[k] > idle_limit) restart_pend[k] = 1'b1;
        end
      end
      return;
    end
    c = p.ch;
    frame_data[c] = 1'b1;
    r.ch = p.ch;
    if (restart_pend[c]) begin
      restart_pend[c] = 1'b0;
      bucket_t0[c] = p.ts;
      open_bytes[c] = 32'd0;
      ring_pos[c] = 0;
      for (int i = 0; i < NBUCKET; i++) begin
        ring_bytes[c][i] = 32'd0;
        ring_ticks[c][i] = 32'd0;
      end
      win_bytes[c] = 32'd0;
      win_ticks[c] = 32'd0;
      if (nominal_bps != 0 && ref_tps != 0) begin
        norm_divide({8'd0, nominal_bps}, 0, ref_tps, 0, nom_mant, nom_exp);
      end else begin
        nom_mant = 32'd0;
        nom_exp = 0;
      end
      r.ratio = NOMINAL_Q31;
      pending_rates.push_back(r);
      return;
    end
    open_bytes[c] += p.nbytes;
    span = p.ts - bucket_t0[c];
    tb_sum = open_bytes[c] + win_bytes[c];
    tt_sum = span + win_ticks[c];
    r.ratio = NOMINAL_Q31;
    if (p.want && tb_sum != 0 && tt_sum != 0 && nom_mant != 0) begin
      norm_divide(tb_sum, 0, tt_sum, 0, m1, e1);
      norm_divide(m1, e1, nom_mant, nom_exp, m2, e2);
      r.ratio = q31_of(m2, e2);
    end
    if (span >= period_ticks) begin
      pos = ring_pos[c];
      win_bytes[c] += open_bytes[c] - ring_bytes[c][pos];
      win_ticks[c] += span - ring_ticks[c][pos];
      ring_bytes[c][pos] = open_bytes[c];
      ring_ticks[c][pos] = span;
      open_bytes[c] = 32'd0;
      bucket_t0[c] = p.ts;
      ring_pos[c] = (pos + 1) % NBUCKET;
    end
    pending_rates.push_back(r);
  endtask

  task automatic push_packet(logic op, logic ch, logic [31:0] ts, logic [15:0] nb,
                             logic want);
    packet_t p;
    p.op = op;
    p.ch = ch;
    p.ts = ts;
    p.nbytes = nb;
    p.want = want;
    packet_queue.push_back(p);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      REG_NOMINAL:    nominal_bps = val[23:0];
      REG_REF_TICKS:  ref_tps = val;
      REG_PERIOD:     period_ticks = val;
      REG_IDLE_LIMIT: idle_limit = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_idle();
    while (packet_queue.size() != 0 || in_valid || pending_rates.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // well-formed frames with random content, plus noise and idle bursts
  task automatic gen_traffic(int n, int step, int bpf);
    int cnt, r, jit, nb;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        push_packet(OP_SOF, 1'($urandom), $urandom, 16'($urandom), 1'($urandom));
        for (int c = 0; c < NCH; c++) begin
          jit = int'($urandom_range(0, step / 8)) - step / 16;
          tsg[c] = tsg[c] + step + jit;
          nb = bpf + int'($urandom_range(0, 8)) - 4;
          if (nb < 0) nb = 0;
          if (nb > 65535) nb = 65535;
          push_packet(OP_DATA, 1'(c), 32'(tsg[c]), 16'(nb), $urandom_range(0, 9) != 0);
        end
        cnt += 3;
      end else if (r < 90) begin
        repeat ($urandom_range(1, 12)) begin
          push_packet(OP_SOF, 1'($urandom), $urandom, 16'($urandom), 1'($urandom));
          cnt++;
        end
      end else begin
        push_packet(OP_DATA, 1'($urandom), $urandom, 16'($urandom_range(0, 65535)),
                    1'($urandom));
        cnt++;
      end
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    in_fire = rst_n && in_valid && !in_stall;
    if (in_fire) begin
      estimate_rate('{in_op, in_channel, in_timestamp, in_byte_count, in_want_rate});
      accepted++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rates.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected transaction: ratio %h ch %0d", out_rate_ratio,
                   out_rate_channel);
      end else begin
        rate_t exp_r;
        exp_r = pending_rates.pop_front();
        if (exp_r.ratio !== out_rate_ratio || exp_r.ch !== out_rate_channel) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected ratio %h ch %0d, got ratio %h ch %0d",
                     exp_r.ratio, exp_r.ch, out_rate_ratio, out_rate_channel);
        end
      end
    end
  end

  always @(negedge clk) begin
    int send_idle, recv_idle;
    packet_t p;
    if (accepted < 320) begin
      send_idle = 32;
      recv_idle = 50;
    end else if (accepted < 640) begin
      send_idle = 50;
      recv_idle = 32;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_idle);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (packet_queue.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        p = packet_queue.pop_front();
        in_op <= p.op;
        in_channel <= p.ch;
        in_timestamp <= p.ts;
        in_byte_count <= p.nbytes;
        in_want_rate <= p.want;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_NOMINAL;
    cfg_wdata = 32'd0;
    in_valid = 1'b0;
    in_op = OP_DATA;
    in_channel = 1'b0;
    in_timestamp = 32'd0;
    in_byte_count = 16'd0;
    in_want_rate = 1'b0;
    out_stall = 1'b0;
    in_fire = 1'b0;
    accepted = 0;
    errors = 0;
    cycles = 0;
    nominal_bps = RST_NOMINAL;
    ref_tps = RST_REF_TICKS;
    period_ticks = RST_PERIOD;
    idle_limit = RST_IDLE_LIMIT;
    nom_mant = 32'd0;
    nom_exp = 0;
    for (int c = 0; c < NCH; c++) begin
      restart_pend[c] = 1'b1;
      frame_data[c] = 1'b0;
      idle_cnt[c] = 8'd0;
      bucket_t0[c] = 32'd0;
      open_bytes[c] = 32'd0;
      ring_pos[c] = 0;
      win_bytes[c] = 32'd0;
      win_ticks[c] = 32'd0;
      tsg[c] = 0;
    end
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed: restart, zero bytes, zero span, saturation, tiny ratio, wrap
    push_packet(OP_DATA, 1'b0, 32'hFFFF_FFF0, 16'd100, 1'b1);
    push_packet(OP_DATA, 1'b0, 32'hFFFF_FFF0, 16'd0, 1'b1);
    push_packet(OP_DATA, 1'b0, 32'hFFFF_FFF0, 16'd5, 1'b1);
    push_packet(OP_DATA, 1'b0, 32'h0000_0010, 16'hFFFF, 1'b1);
    push_packet(OP_DATA, 1'b0, 32'h0000_0020, 16'd1, 1'b0);
    push_packet(OP_DATA, 1'b1, 32'd0, 16'd0, 1'b1);
    push_packet(OP_DATA, 1'b1, 32'd100000, 16'd0, 1'b1);
    push_packet(OP_DATA, 1'b1, 32'h7FFF_FFFF, 16'd1, 1'b1);
    push_packet(OP_DATA, 1'b1, 32'hFFFF_FFFF, 16'd128, 1'b1);
    push_packet(OP_DATA, 1'b1, 32'hFFFF_FFFF, 16'd0, 1'b1);
    for (int i = 0; i < 10; i++)
      push_packet(OP_SOF, i[0], 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    push_packet(OP_DATA, 1'b0, 32'd5000, 16'd128, 1'b1);
    push_packet(OP_DATA, 1'b1, 32'd5000, 16'd128, 1'b1);
    push_packet(OP_DATA, 1'b0, 32'd105000, 16'd128, 1'b1);
    wait_idle();

    write_reg(REG_NOMINAL, 32'd192000);
    write_reg(REG_REF_TICKS, 32'd100000000);
    write_reg(REG_PERIOD, 32'd200000);
    write_reg(REG_IDLE_LIMIT, 32'd3);
    gen_traffic(300, 100000, 192);
    wait_idle();

    write_reg(REG_NOMINAL, 32'hFF_FFFF);
    write_reg(REG_REF_TICKS, 32'd1);
    write_reg(REG_PERIOD, 32'd1);
    write_reg(REG_IDLE_LIMIT, 32'd0);
    gen_traffic(150, 50, 65000);
    wait_idle();

    write_reg(REG_NOMINAL, 32'd1);
    write_reg(REG_REF_TICKS, 32'hFFFF_FFFF);
    write_reg(REG_PERIOD, 32'hFFFF_FFFF);
    write_reg(REG_IDLE_LIMIT, 32'd255);
    gen_traffic(150, 3000000, 1);
    wait_idle();

    write_reg(REG_NOMINAL, 32'd96000);
    write_reg(REG_REF_TICKS, 32'd24576000);
    write_reg(REG_PERIOD, 32'd49152);
    write_reg(REG_IDLE_LIMIT, 32'd8);
    gen_traffic(330, 24576, 96);
    wait_idle();

    if (errors == 0 && pending_rates.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/usbare_pkg.sv
src/usbare_div.sv
src/usb_audio_rate_estimator_top.sv
tb/tb_top.sv
